@@ design/selective_repeat_receiver_core_assert.svh @@
// assertion macros shared by the receiver core
`ifndef SELECTIVE_REPEAT_RECEIVER_CORE_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVER_CORE_ASSERT_SVH

// same-cycle implication, checked on clk outside reset
`define SRR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("receiver check failed");

// next-cycle implication, checked on clk outside reset
`define SRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("receiver check failed");

`endif

@@ design/srr_pkg.sv @@
// package: types, codes and constants of the selective-repeat receiver
package srr_pkg;

  localparam int SRR_WINDOW_DEPTH = 16;
  localparam int SRR_MAX_PAYLOAD  = 1024;

  localparam int SEQ_W = 16;
  localparam int LEN_W = 11;
  localparam int REF_W = 32;

  // result kinds
  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_DUP     = 2'd1,
    KIND_DELIVER = 2'd2
  } kind_t;

  // operations of the shared sequence-number adder
  typedef enum logic [1:0] {
    ALU_SUB = 2'd0,
    ALU_INC = 2'd1,
    ALU_DEC = 2'd2
  } alu_op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AHEAD,
    ST_BEHIND,
    ST_CLASS,
    ST_OLD,
    ST_READ,
    ST_DELIVER
  } state_t;

  // one held packet in a ring slot
  typedef struct packed {
    logic             last;
    logic [LEN_W-1:0] length;
    logic [REF_W-1:0] pref;
  } slot_entry_t;

endpackage

@@ design/srr_alu.sv @@
// shared 16-bit modulo adder: subtract, increment, decrement
module srr_alu (
  input  srr_pkg::alu_op_t         op,
  input  logic [srr_pkg::SEQ_W-1:0] a,
  input  logic [srr_pkg::SEQ_W-1:0] b,
  output logic [srr_pkg::SEQ_W-1:0] res
);

  logic [srr_pkg::SEQ_W-1:0] b_eff;
  logic                      cin;

  // operand select, then one carry-in adder
  always_comb begin
    unique case (op)
      srr_pkg::ALU_SUB: begin
        b_eff = ~b;
        cin   = 1'b1;
      end
      srr_pkg::ALU_INC: begin
        b_eff = srr_pkg::SEQ_W'(1);
        cin   = 1'b0;
      end
      srr_pkg::ALU_DEC: begin
        b_eff = '1;
        cin   = 1'b0;
      end
      default: begin
        b_eff = ~b;
        cin   = 1'b1;
      end
    endcase
    res = a + b_eff + srr_pkg::SEQ_W'(cin);
  end

endmodule

@@ design/srr_slot_store.sv @@
// ring slot store: valid flops plus packet memory with registered read
module srr_slot_store #(
  parameter int WINDOW_DEPTH = srr_pkg::SRR_WINDOW_DEPTH,
  localparam int IW = $clog2(WINDOW_DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  logic [IW-1:0]          wr_idx,
  input  srr_pkg::slot_entry_t   wr_data,
  input  logic                   clr_en,
  input  logic [IW-1:0]          clr_idx,
  input  logic                   rd_en,
  input  logic [IW-1:0]          rd_idx,
  output srr_pkg::slot_entry_t   rd_data,
  output logic [WINDOW_DEPTH-1:0] valid
);

  srr_pkg::slot_entry_t      mem [WINDOW_DEPTH];
  srr_pkg::slot_entry_t      rd_data_r;
  logic [WINDOW_DEPTH-1:0]   valid_r;
  logic [WINDOW_DEPTH-1:0]   valid_nxt;

  // valid bits: set on store, cleared on delivery
  always_comb begin
    valid_nxt = valid_r;
    if (wr_en)  valid_nxt[wr_idx]  = 1'b1;
    if (clr_en) valid_nxt[clr_idx] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // packet memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;
  assign valid   = valid_r;

endmodule

@@ design/selective_repeat_receiver_core.sv @@
// top level: selective-repeat receiver sequencer with output register
//
//   channel | ports                                    | direction
//   in      | in_valid/in_ready, in_seq_num .. payload | packet descriptors in
//   out     | out_valid/out_ready, out_kind .. done    | acks and deliveries out
//
// an item goes through the classify sequence (accept, two passes of the shared
// adder, classify); an old packet outside the window also passes the old state
// each in-order delivery is a slot memory read, then emit
// reset is synchronous active low and clears the window, counters and flags
// a stalled output holds the sequencer in its emitting state; no input is
// taken until the item's last result has been loaded into the output register
module selective_repeat_receiver_core #(
  parameter int WINDOW_DEPTH = srr_pkg::SRR_WINDOW_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [15:0]               in_seq_num,
  input  logic                      in_last_flag,
  input  logic [10:0]               in_payload_length,
  input  logic [31:0]               in_payload_ref,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_kind,
  output logic [15:0]               out_ack_num,
  output logic                      out_last,
  output logic [10:0]               out_length,
  output logic [31:0]               out_ref,
  output logic                      out_end_of_run,
  output logic                      out_transfer_done
);

  localparam int IW = $clog2(WINDOW_DEPTH);
  localparam int GW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [IW:0]   W_IDX  = (IW + 1)'(WINDOW_DEPTH);
  localparam logic [IW-1:0] HEAD_MAX = IW'(WINDOW_DEPTH - 1);
  localparam logic [GW-1:0] W_GRD  = GW'(WINDOW_DEPTH);
  localparam logic [15:0]   W_SEQ  = 16'(WINDOW_DEPTH);
  localparam logic [16:0]   MAX_LEN = 17'(srr_pkg::SRR_MAX_PAYLOAD);

  srr_pkg::state_t state_r, state_nxt;

  // latched packet
  logic [15:0] seq_r, seq_nxt;
  logic        last_r, last_nxt;
  logic [10:0] len_r, len_nxt;
  logic [31:0] ref_r, ref_nxt;

  // receiver state
  logic [15:0]   exp_r, exp_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic          done_r, done_nxt;
  logic [GW-1:0] guard_r, guard_nxt;
  logic [15:0]   ahead_r, ahead_nxt;
  logic [15:0]   behind_r, behind_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [15:0] out_num_r, out_num_nxt;
  logic        out_last_r, out_last_nxt;
  logic [10:0] out_len_r, out_len_nxt;
  logic [31:0] out_ref_r, out_ref_nxt;
  logic        out_end_r, out_end_nxt;
  logic        out_done_r, out_done_nxt;

  // shared adder
  srr_pkg::alu_op_t alu_op;
  logic [15:0]      alu_a, alu_b, alu_res;

  // slot store
  logic                     st_wr_en, st_clr_en, st_rd_en;
  srr_pkg::slot_entry_t     st_wr_data, st_rd_data;
  logic [WINDOW_DEPTH-1:0]  st_valid;

  // classify and drain decisions
  logic          out_free;
  logic          win_hit, slot_hit, beh_hit, class_emit;
  logic [IW:0]   idx_sum;
  logic [IW-1:0] slot_idx, head_inc;
  logic [GW-1:0] guard_inc;
  logic          drain_more;
  logic [10:0]   len_clamped;
  logic          emit;

  srr_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  srr_slot_store #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (st_wr_en),
    .wr_idx  (slot_idx),
    .wr_data (st_wr_data),
    .clr_en  (st_clr_en),
    .clr_idx (head_r),
    .rd_en   (st_rd_en),
    .rd_idx  (head_r),
    .rd_data (st_rd_data),
    .valid   (st_valid)
  );

  // window position and ring arithmetic
  assign out_free  = !out_valid_r || out_ready;
  assign win_hit   = ahead_r < W_SEQ;
  assign beh_hit   = (behind_r != 16'd0) && (behind_r <= W_SEQ);
  assign idx_sum   = {1'b0, head_r} + {1'b0, ahead_r[IW-1:0]};
  assign slot_idx  = (idx_sum >= W_IDX) ? IW'(idx_sum - W_IDX) : idx_sum[IW-1:0];
  assign slot_hit  = st_valid[slot_idx];
  assign head_inc  = (head_r == HEAD_MAX) ? '0 : head_r + 1'b1;
  assign guard_inc = guard_r + 1'b1;
  assign drain_more = !st_rd_data.last && st_valid[head_inc] && (guard_inc < W_GRD);
  assign class_emit = done_r || win_hit || beh_hit;
  assign len_clamped = ({6'd0, in_payload_length} > MAX_LEN) ? 11'(srr_pkg::SRR_MAX_PAYLOAD)
                                                            : in_payload_length;
  assign st_wr_data = '{last: last_r, length: len_r, pref: ref_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srr_pkg::ST_IDLE:   if (in_valid) state_nxt = srr_pkg::ST_AHEAD;
      srr_pkg::ST_AHEAD:  state_nxt = srr_pkg::ST_BEHIND;
      srr_pkg::ST_BEHIND: state_nxt = srr_pkg::ST_CLASS;
      srr_pkg::ST_CLASS: begin
        if (!class_emit) begin
          state_nxt = srr_pkg::ST_OLD;
        end else if (out_free) begin
          if (!done_r && win_hit && !slot_hit && (ahead_r == 16'd0)) begin
            state_nxt = srr_pkg::ST_READ;
          end else begin
            state_nxt = srr_pkg::ST_IDLE;
          end
        end
      end
      srr_pkg::ST_OLD:     if (out_free) state_nxt = srr_pkg::ST_IDLE;
      srr_pkg::ST_READ:    state_nxt = srr_pkg::ST_DELIVER;
      srr_pkg::ST_DELIVER: begin
        if (out_free) state_nxt = drain_more ? srr_pkg::ST_READ : srr_pkg::ST_IDLE;
      end
      default: state_nxt = srr_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath next values
  always_comb begin
    in_ready   = 1'b0;
    alu_op     = srr_pkg::ALU_SUB;
    alu_a      = seq_r;
    alu_b      = exp_r;
    st_wr_en   = 1'b0;
    st_clr_en  = 1'b0;
    st_rd_en   = 1'b0;
    emit       = 1'b0;

    seq_nxt    = seq_r;
    last_nxt   = last_r;
    len_nxt    = len_r;
    ref_nxt    = ref_r;
    exp_nxt    = exp_r;
    head_nxt   = head_r;
    done_nxt   = done_r;
    guard_nxt  = guard_r;
    ahead_nxt  = ahead_r;
    behind_nxt = behind_r;

    out_kind_nxt = out_kind_r;
    out_num_nxt  = out_num_r;
    out_last_nxt = out_last_r;
    out_len_nxt  = out_len_r;
    out_ref_nxt  = out_ref_r;
    out_end_nxt  = out_end_r;
    out_done_nxt = out_done_r;

    unique case (state_r)
      srr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          seq_nxt   = in_seq_num;
          last_nxt  = in_last_flag;
          len_nxt   = len_clamped;
          ref_nxt   = in_payload_ref;
          guard_nxt = '0;
        end
      end
      srr_pkg::ST_AHEAD: begin
        ahead_nxt = alu_res;
      end
      srr_pkg::ST_BEHIND: begin
        alu_a      = exp_r;
        alu_b      = seq_r;
        behind_nxt = alu_res;
      end
      srr_pkg::ST_CLASS: begin
        if (class_emit && out_free) begin
          emit         = 1'b1;
          out_kind_nxt = srr_pkg::KIND_DUP;
          out_num_nxt  = seq_r;
          out_last_nxt = last_r;
          out_len_nxt  = '0;
          out_ref_nxt  = '0;
          out_end_nxt  = 1'b1;
          out_done_nxt = done_r;
          // new packet inside the window: store and ack
          if (!done_r && win_hit && !slot_hit) begin
            st_wr_en     = 1'b1;
            out_kind_nxt = srr_pkg::KIND_ACK;
            out_end_nxt  = (ahead_r != 16'd0);
          end
        end
      end
      srr_pkg::ST_OLD: begin
        alu_op = srr_pkg::ALU_DEC;
        alu_a  = exp_r;
        if (out_free) begin
          emit         = 1'b1;
          out_kind_nxt = srr_pkg::KIND_DUP;
          out_num_nxt  = (exp_r == 16'd0) ? 16'd0 : alu_res;
          out_last_nxt = last_r;
          out_len_nxt  = '0;
          out_ref_nxt  = '0;
          out_end_nxt  = 1'b1;
          out_done_nxt = done_r;
        end
      end
      srr_pkg::ST_READ: begin
        st_rd_en = 1'b1;
      end
      srr_pkg::ST_DELIVER: begin
        alu_op = srr_pkg::ALU_INC;
        alu_a  = exp_r;
        if (out_free) begin
          emit         = 1'b1;
          st_clr_en    = 1'b1;
          out_kind_nxt = srr_pkg::KIND_DELIVER;
          out_num_nxt  = exp_r;
          out_last_nxt = st_rd_data.last;
          out_len_nxt  = st_rd_data.length;
          out_ref_nxt  = st_rd_data.pref;
          out_end_nxt  = !drain_more;
          out_done_nxt = done_r || st_rd_data.last;
          done_nxt     = done_r || st_rd_data.last;
          exp_nxt      = alu_res;
          head_nxt     = head_inc;
          guard_nxt    = guard_inc;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase

    // output register valid: load on emit, drop on transfer
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srr_pkg::ST_IDLE;
      exp_r       <= '0;
      head_r      <= '0;
      done_r      <= 1'b0;
      guard_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      head_r      <= head_nxt;
      done_r      <= done_nxt;
      guard_r     <= guard_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    seq_r      <= seq_nxt;
    last_r     <= last_nxt;
    len_r      <= len_nxt;
    ref_r      <= ref_nxt;
    ahead_r    <= ahead_nxt;
    behind_r   <= behind_nxt;
    out_kind_r <= out_kind_nxt;
    out_num_r  <= out_num_nxt;
    out_last_r <= out_last_nxt;
    out_len_r  <= out_len_nxt;
    out_ref_r  <= out_ref_nxt;
    out_end_r  <= out_end_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_ack_num       = out_num_r;
  assign out_last          = out_last_r;
  assign out_length        = out_len_r;
  assign out_ref           = out_ref_r;
  assign out_end_of_run    = out_end_r;
  assign out_transfer_done = out_done_r;

`include "selective_repeat_receiver_core_assert.svh"

  `SRR_ASSERT_NEXT(a_done_sticky, done_r, done_r)
  `SRR_ASSERT_NEXT(a_exp_step, 1'b1, (exp_r == $past(exp_r)) || (exp_r == $past(exp_r) + 16'd1))
  `SRR_ASSERT_NOW(a_drain_head_held, state_r == srr_pkg::ST_DELIVER, st_valid[head_r])
  `SRR_ASSERT_NOW(a_guard_bound, 1'b1, guard_r <= W_GRD)

endmodule

@@ tb/srr_delivery_checker.sv @@
`timescale 1ns / 100ps
// receive window predictor and out channel comparator for the receiver core
module srr_delivery_checker
  import srr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [SEQ_W-1:0] in_seq_num,
  input  logic             in_last_flag,
  input  logic [LEN_W-1:0] in_payload_length,
  input  logic [REF_W-1:0] in_payload_ref,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [1:0]       out_kind,
  input  logic [SEQ_W-1:0] out_ack_num,
  input  logic             out_last,
  input  logic [LEN_W-1:0] out_length,
  input  logic [REF_W-1:0] out_ref,
  input  logic             out_end_of_run,
  input  logic             out_transfer_done,
  output int               error_count,
  output int               pending_results
);

  // one ack or delivery as it should leave the block
  typedef struct packed {
    kind_t            kind;
    logic [SEQ_W-1:0] ack_num;
    logic             last;
    logic [LEN_W-1:0] length;
    logic [REF_W-1:0] pref;
    logic             end_of_run;
    logic             done;
  } rx_result_t;

  rx_result_t       expected_results[$];

  // shadow of the receive window
  logic [SEQ_W-1:0] next_seq;
  int               head_slot;
  bit               slot_held[SRR_WINDOW_DEPTH];
  slot_entry_t      slot_data[SRR_WINDOW_DEPTH];
  bit               xfer_done;

  function automatic rx_result_t make_result(kind_t k, logic [SEQ_W-1:0] num, logic l,
                                             logic [LEN_W-1:0] len, logic [REF_W-1:0] pref);
    rx_result_t r;
    r.kind       = k;
    r.ack_num    = num;
    r.last       = l;
    r.length     = len;
    r.pref       = pref;
    r.end_of_run = 1'b0;
    r.done       = xfer_done;
    return r;
  endfunction

  // classify one descriptor, update the window and queue what it causes
  task automatic predict_packet(input logic [SEQ_W-1:0] seq, input logic last,
                                input logic [LEN_W-1:0] raw_len, input logic [REF_W-1:0] pref);
    logic [SEQ_W-1:0] ahead;
    logic [SEQ_W-1:0] behind;
    logic [LEN_W-1:0] len;
    int               idx;
    int               drained;
    rx_result_t       batch[$];
    rx_result_t       tail;
    ahead  = SEQ_W'(seq - next_seq);
    behind = SEQ_W'(next_seq - seq);
    len    = (raw_len > LEN_W'(SRR_MAX_PAYLOAD)) ? LEN_W'(SRR_MAX_PAYLOAD) : raw_len;
    if (xfer_done) begin
      batch.push_back(make_result(KIND_DUP, seq, last, '0, '0));
    end else if (ahead < SRR_WINDOW_DEPTH) begin
      idx = (head_slot + int'(ahead)) % SRR_WINDOW_DEPTH;
      if (slot_held[idx]) begin
        batch.push_back(make_result(KIND_DUP, seq, last, '0, '0));
      end else begin
        slot_held[idx]        = 1'b1;
        slot_data[idx].last   = last;
        slot_data[idx].length = len;
        slot_data[idx].pref   = pref;
        batch.push_back(make_result(KIND_ACK, seq, last, '0, '0));
        // expected packet: drain the contiguous run, stop after the final one
        if (ahead == 0) begin
          drained = 0;
          while (slot_held[head_slot] && !xfer_done && drained < SRR_WINDOW_DEPTH) begin
            slot_held[head_slot] = 1'b0;
            if (slot_data[head_slot].last) xfer_done = 1'b1;
            batch.push_back(make_result(KIND_DELIVER, next_seq, slot_data[head_slot].last,
                                        slot_data[head_slot].length,
                                        slot_data[head_slot].pref));
            next_seq  = SEQ_W'(next_seq + 1'b1);
            head_slot = (head_slot + 1) % SRR_WINDOW_DEPTH;
            drained++;
          end
        end
      end
    end else if (behind >= 1 && behind <= SRR_WINDOW_DEPTH) begin
      batch.push_back(make_result(KIND_DUP, seq, last, '0, '0));
    end else begin
      // out of range: re-ack the newest delivered number, 0 before any
      batch.push_back(make_result(KIND_DUP,
                                  (next_seq != 0) ? SEQ_W'(next_seq - 1'b1) : '0,
                                  last, '0, '0));
    end
    tail = batch.pop_back();
    tail.end_of_run = 1'b1;
    batch.push_back(tail);
    foreach (batch[i]) expected_results.push_back(batch[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    rx_result_t want;
    if (!rst_n) begin
      expected_results.delete();
      next_seq  = '0;
      head_slot = 0;
      xfer_done = 1'b0;
      for (int i = 0; i < SRR_WINDOW_DEPTH; i++) begin
        slot_held[i] = 1'b0;
        slot_data[i] = '0;
      end
    end else begin
      if (in_valid && in_ready)
        predict_packet(in_seq_num, in_last_flag, in_payload_length, in_payload_ref);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual kind %0h num %0h",
                   $time, out_kind, out_ack_num);
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("ack_num", want.ack_num, out_ack_num);
          check_field("last", want.last, out_last);
          check_field("length", want.length, out_length);
          check_field("ref", want.pref, out_ref);
          check_field("end_of_run", want.end_of_run, out_end_of_run);
          check_field("transfer_done", want.done, out_transfer_done);
        end
      end
    end
    pending_results = expected_results.size();
  end

endmodule

@@ tb/tb_selective_repeat_receiver_core.sv @@
`timescale 1ns / 100ps
// testbench top: descriptor stimulus, out channel stalls and verdict for the receiver core
module tb_selective_repeat_receiver_core;
  import srr_pkg::*;

  // the fast-forward to the wrap dominates the run time
  localparam int RUN_LIMIT    = 4_000_000;
  localparam int RANDOM_ITEMS = 360;
  localparam int FF_TARGET    = 65488;

  typedef enum int {
    NOISE_RESEND,
    NOISE_BEHIND,
    NOISE_FAR
  } noise_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [SEQ_W-1:0] in_seq_num;
  logic             in_last_flag;
  logic [LEN_W-1:0] in_payload_length;
  logic [REF_W-1:0] in_payload_ref;
  logic             out_valid;
  logic             out_ready;
  logic [1:0]       out_kind;
  logic [SEQ_W-1:0] out_ack_num;
  logic             out_last;
  logic [LEN_W-1:0] out_length;
  logic [REF_W-1:0] out_ref;
  logic             out_end_of_run;
  logic             out_transfer_done;
  int               error_count;
  int               pending_results;

  // window base the sender works from, and packets sent in the current block
  logic [SEQ_W-1:0] cursor;
  logic [SEQ_W-1:0] block_sent[$];
  bit               quiet;
  bit               fast_forward;
  int               items_sent;
  int               cycle_count;

  selective_repeat_receiver_core dut (.*);

  srr_delivery_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("selective_repeat_receiver_core test failed");
      $finish;
    end
  end

  function automatic logic [LEN_W-1:0] draw_length();
    if ($urandom_range(0, 7) == 0) return LEN_W'($urandom_range(1025, 2047));
    return LEN_W'($urandom_range(0, 1024));
  endfunction

  // one descriptor transfer, preceded by a random gap unless quiet
  task automatic send_descriptor(input logic [SEQ_W-1:0] seq, input logic last,
                                 input logic [LEN_W-1:0] len, input logic [REF_W-1:0] pref);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_seq_num        <= seq;
    in_last_flag      <= last;
    in_payload_length <= len;
    in_payload_ref    <= pref;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (!fast_forward) items_sent++;
  endtask

  // descriptors that must never be stored: resends, stale and far-off numbers
  task automatic send_noise(input noise_t flavor);
    logic [SEQ_W-1:0] seq;
    if (flavor == NOISE_RESEND && block_sent.size() > 0)
      seq = block_sent[$urandom_range(0, block_sent.size() - 1)];
    else if (flavor == NOISE_FAR)
      seq = SEQ_W'(cursor + 32 + $urandom_range(0, 65487));
    else
      seq = SEQ_W'(cursor - $urandom_range(1, 16));
    send_descriptor(seq, 1'(($urandom_range(0, 1))), draw_length(), $urandom());
  endtask

  // a block of consecutive packets in shuffled order with noise mixed in
  task automatic run_block();
    int n;
    int j;
    int swap;
    int order[SRR_WINDOW_DEPTH];
    quiet = ($urandom_range(0, 3) == 0);
    block_sent.delete();
    n = $urandom_range(1, SRR_WINDOW_DEPTH);
    // land exactly on zero when crossing the wrap
    if (cursor != 0 && n > 65536 - int'(cursor)) n = 65536 - int'(cursor);
    if (cursor == 0) send_noise(NOISE_FAR);
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      swap     = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) send_noise(noise_t'($urandom_range(0, 2)));
      send_descriptor(SEQ_W'(cursor + order[i]), 1'b0, draw_length(), $urandom());
      block_sent.push_back(SEQ_W'(cursor + order[i]));
    end
    cursor = SEQ_W'(cursor + n);
  endtask

  // out channel: random stall before each transfer unless quiet
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin
    int n;
    int k;
    in_valid          = 1'b0;
    in_seq_num        = '0;
    in_last_flag      = 1'b0;
    in_payload_length = '0;
    in_payload_ref    = '0;
    quiet             = 1'b0;
    fast_forward      = 1'b0;
    items_sent        = 0;
    cursor            = '0;
    rst_n             = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: range edges around an empty window at zero
    send_descriptor(16'd100, 1'b1, 11'd0, 32'h0000_0000);
    send_descriptor(16'd65535, 1'b1, 11'd1024, 32'hFFFF_FFFF);
    send_descriptor(16'd65520, 1'b0, 11'd1, 32'h0000_0001);
    send_descriptor(16'd65519, 1'b1, 11'd2047, $urandom());
    send_descriptor(16'd16, 1'b1, 11'd5, $urandom());
    // top of window with oversized length, then its resend
    send_descriptor(16'd15, 1'b0, 11'd2047, 32'hFFFF_FFFF);
    send_descriptor(16'd15, 1'b1, 11'd3, 32'h0000_0000);
    // fill the window backwards, then the head drains all sixteen
    for (int s = 14; s >= 1; s--)
      send_descriptor(SEQ_W'(s), 1'b0, (s % 3 == 0) ? 11'd1025 : (s % 3 == 1) ? 11'd1024 : 11'd0,
                      $urandom());
    send_descriptor(16'd0, 1'b0, 11'd1025, 32'hA5A5_5A5A);
    // just delivered, both ends of the stale range
    send_descriptor(16'd15, 1'b1, 11'd0, 32'h0000_0000);
    send_descriptor(16'd0, 1'b0, 11'd0, 32'h0000_0000);
    cursor = 16'd16;

    // random blocks low in the number space
    while (items_sent < RANDOM_ITEMS / 2) run_block();

    // hold off until every result is out
    @(negedge clk) in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);

    // full blocks in reverse order at full rate up to just below the wrap
    quiet        = 1'b1;
    fast_forward = 1'b1;
    while (cursor != FF_TARGET) begin
      n = (FF_TARGET - int'(cursor) < SRR_WINDOW_DEPTH) ? FF_TARGET - int'(cursor)
                                                       : SRR_WINDOW_DEPTH;
      for (int i = n - 1; i >= 0; i--)
        send_descriptor(SEQ_W'(cursor + i), 1'b0, draw_length(), $urandom());
      cursor = SEQ_W'(cursor + n);
    end
    fast_forward = 1'b0;

    // random blocks across the wrap
    while (items_sent < RANDOM_ITEMS) run_block();

    // closing block: final packet inside, later packets stay held
    quiet = 1'b0;
    n     = $urandom_range(3, 12);
    k     = $urandom_range(0, n - 2);
    for (int i = n - 1; i >= 1; i--)
      send_descriptor(SEQ_W'(cursor + i), (i == k), draw_length(), $urandom());
    send_descriptor(cursor, (k == 0), draw_length(), $urandom());

    // anything after the finished transfer
    repeat (12)
      send_descriptor(SEQ_W'($urandom_range(0, 65535)), 1'(($urandom_range(0, 1))),
                      draw_length(), $urandom());

    @(negedge clk) in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (24) @(negedge clk);

    if (error_count == 0 && pending_results == 0) begin
      $display("selective_repeat_receiver_core test passed");
    end else begin
      $display("selective_repeat_receiver_core test failed");
    end
    $finish;
  end

endmodule

@@ selective_repeat_receiver_core.f @@
+incdir+design
design/srr_pkg.sv
design/srr_alu.sv
design/srr_slot_store.sv
design/selective_repeat_receiver_core.sv
tb/srr_delivery_checker.sv
tb/tb_selective_repeat_receiver_core.sv
